### hdl/ersm_pkg.sv
// ----------------------------------------------------------------------------
// ersm_pkg
// Shared types and constants of the expected reply stream matcher.
// ----------------------------------------------------------------------------
package ersm_pkg;

  localparam int unsigned BUFFER_LIMIT = 255;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned CHAR_W     = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2,
    REG_MAX_CHARS      = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    STATUS_SEARCH = 2'd0,
    STATUS_MATCH  = 2'd1,
    STATUS_LIMIT  = 2'd2
  } status_e;

  typedef struct packed {
    logic [63:0]       pattern_low;
    logic [63:0]       pattern_high;
    logic [LEN_W-1:0]  pattern_length;
    logic [CHAR_W-1:0] max_chars;
  } cfg_t;

  typedef struct packed {
    status_e           status;
    logic [CHAR_W-1:0] chars_seen;
  } res_t;

  localparam logic [63:0]       PATTERN_LOW_RST    = 64'h4B4F;
  localparam logic [63:0]       PATTERN_HIGH_RST   = 64'h0;
  localparam logic [LEN_W-1:0]  PATTERN_LENGTH_RST = 5'd2;
  localparam logic [CHAR_W-1:0] MAX_CHARS_RST      = 8'd240;

endpackage

### hdl/ersm_cfg_regs.sv
// ----------------------------------------------------------------------------
// ersm_cfg_regs
// Configuration register file: pattern words, pattern length, char limit.
// ----------------------------------------------------------------------------
module ersm_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ersm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ersm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output ersm_pkg::cfg_t                      cfg_o
);
  import ersm_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_PATTERN_LOW:    cfg_d.pattern_low    = cfg_data_i;
        REG_PATTERN_HIGH:   cfg_d.pattern_high   = cfg_data_i;
        REG_PATTERN_LENGTH: cfg_d.pattern_length = cfg_data_i[LEN_W-1:0];
        REG_MAX_CHARS:      cfg_d.max_chars      = cfg_data_i[CHAR_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_low    <= PATTERN_LOW_RST;
      cfg_q.pattern_high   <= PATTERN_HIGH_RST;
      cfg_q.pattern_length <= PATTERN_LENGTH_RST;
      cfg_q.max_chars      <= MAX_CHARS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/ersm_match.sv
// ----------------------------------------------------------------------------
// ersm_match
// Byte history, search counter and parallel window compare.
// ----------------------------------------------------------------------------
module ersm_match #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ersm_pkg::cfg_t               cfg_i,
  input  logic [ersm_pkg::CHAR_W-1:0]  byte_i,
  input  logic                         step_i,
  output ersm_pkg::res_t               res_o
);
  import ersm_pkg::*;

  localparam int unsigned HIST_DEPTH = PATTERN_MAX - 1;
  localparam int unsigned IDX_W      = $clog2(PATTERN_MAX);
  localparam logic [LEN_W-1:0]  LEN_CAP   = LEN_W'(PATTERN_MAX);
  localparam logic [CHAR_W-1:0] LIMIT_CAP = CHAR_W'(BUFFER_LIMIT);

  logic [CHAR_W-1:0] hist_q [HIST_DEPTH];
  logic [CHAR_W-1:0] count_q;
  logic [CHAR_W-1:0] count_d;

  logic [CHAR_W-1:0] window [PATTERN_MAX];
  logic [127:0]      pattern;
  logic [LEN_W-1:0]  len;
  logic [CHAR_W-1:0] limit;
  logic [CHAR_W-1:0] count;
  logic [LEN_W-1:0]  idx;
  logic              match;
  status_e           status;

  assign pattern = {cfg_i.pattern_high, cfg_i.pattern_low};

  always_comb begin
    len = (cfg_i.pattern_length > LEN_CAP) ? LEN_CAP : cfg_i.pattern_length;
    limit = (cfg_i.max_chars > LIMIT_CAP) ? LIMIT_CAP : cfg_i.max_chars;
    if (limit == '0) begin
      limit = CHAR_W'(1);
    end
    count = (count_q == '1) ? count_q : count_q + CHAR_W'(1);
  end

  always_comb begin
    window[0] = byte_i;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      window[j] = hist_q[j-1];
    end
  end

  always_comb begin
    match = (count >= {{(CHAR_W-LEN_W){1'b0}}, len});
    idx   = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (LEN_W'(i) < len) begin
        idx = len - LEN_W'(i) - LEN_W'(1);
        if (pattern[i*8 +: 8] != window[idx[IDX_W-1:0]]) begin
          match = 1'b0;
        end
      end
    end
  end

  always_comb begin
    if (match) begin
      status = STATUS_MATCH;
    end else if (count >= limit) begin
      status = STATUS_LIMIT;
    end else begin
      status = STATUS_SEARCH;
    end
    count_d = (status != STATUS_SEARCH) ? '0 : count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int j = 0; j < HIST_DEPTH; j++) begin
        hist_q[j] <= '0;
      end
    end else if (step_i) begin
      count_q   <= count_d;
      hist_q[0] <= byte_i;
      for (int j = 1; j < HIST_DEPTH; j++) begin
        hist_q[j] <= hist_q[j-1];
      end
    end
  end

  assign res_o.status     = status;
  assign res_o.chars_seen = count;

endmodule

### hdl/expected_reply_stream_matcher_top.sv
// ----------------------------------------------------------------------------
// expected_reply_stream_matcher_top
// Watches a received byte stream for a configured reply string.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one received byte (rx_byte_i)
// per request. Output channel: out_valid_o / out_stall_i carry one result per
// request: status_o (searching, matched, limit reached) and chars_seen_o.
// A request accepted into the input register is compared against the pattern
// and the byte history, and its result is registered in the output register
// as the request advances. One request per cycle is sustained while the output
// does not stall; the single compare stage between the registers sets that.
// The history and search count advance as a request moves to the output
// register, so each byte sees the state left by the one before it.
// When the receiver stalls, the output holds and the input register fills;
// in_stall_o rises only when both registers are full and the output stalls.
// Reset clears both valid flags, the history, the count and restores the
// configuration defaults (pattern "OK", length 2, limit 240).
// Write the configuration port only while no request is in flight.
// ----------------------------------------------------------------------------
module expected_reply_stream_matcher_top #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ersm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ersm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ersm_pkg::CHAR_W-1:0]      rx_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic [ersm_pkg::CHAR_W-1:0]      chars_seen_o
);
  import ersm_pkg::*;

  cfg_t              cfg;
  res_t              res;
  logic              in_valid_q;
  logic [CHAR_W-1:0] in_byte_q;
  logic              out_valid_q;
  res_t              out_res_q;
  logic              advance;
  logic              in_accept;

  ersm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ersm_match #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .byte_i (in_byte_q),
    .step_i (advance),
    .res_o  (res)
  );

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_res_q.status;
  assign chars_seen_o = out_res_q.chars_seen;

endmodule
